@@ design/pse_pkg.sv @@
// Types and codes shared by the plurality size estimator.
package pse_pkg;

  localparam int unsigned SIZE_W  = 64;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned COUNT_W = 5;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [INDEX_W-1:0] site_index;
    logic [SIZE_W-1:0]  size_value;
  } pse_in_t;

  typedef struct packed {
    logic               changed;
    logic               table_full;
    logic [SIZE_W-1:0]  estimated_size;
    logic [COUNT_W-1:0] site_count;
  } pse_out_t;

endpackage

@@ design/plurality_size_estimator.sv @@
// Plurality size estimator: slot table in a synchronous memory, recount by slot walk.
//
//   channel   ports                    handshake
//   --------  -----------------------  ---------------------------------------
//   request   start, busy, in_data     taken at a clock edge with start & !busy
//   result    out_valid, out_data      one-cycle strobe, one result per request
//
// A request that leaves the table as it was goes from the check state straight
// to the result strobe; the next request is taken only once the block is idle
// again. A change runs a recount that walks the slot memory: an outer pass over
// all slots and, for each occupied slot with a nonzero size, an inner pass that
// reads every slot through the single read port. Reset (synchronous, rst_n low)
// empties the table and zeroes the estimate; the memory needs no clear.
// The result cannot be held off by the receiver.
module plurality_size_estimator #(
  parameter int unsigned SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  pse_pkg::pse_in_t in_data,
  output logic             out_valid,
  output pse_pkg::pse_out_t out_data
);
  import pse_pkg::*;

  localparam int unsigned IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNTW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_CHECK     = 8'b0000_0010,
    S_OUTER     = 8'b0000_0100,
    S_OUTER_CHK = 8'b0000_1000,
    S_INNER     = 8'b0001_0000,
    S_INNER_END = 8'b0010_0000,
    S_FINAL     = 8'b0100_0000,
    S_DONE      = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // slot memory
  logic [SIZE_W-1:0] mem [SLOTS];
  logic [SIZE_W-1:0] rd_data_r;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     wr_addr;
  logic              mem_we;

  pse_in_t           req_r;
  logic [SLOTS-1:0]  valid_r;
  logic [CNTW-1:0]   count_r;
  logic [SIZE_W-1:0] est_r;
  logic              changed_r;
  logic              full_r;

  logic [IW-1:0]     i_r, j_r, pj_r;
  logic              pend_r;
  logic [SIZE_W-1:0] v_r;
  logic [CNTW-1:0]   cnt_r;
  logic [SIZE_W-1:0] best_r, largest_r;
  logic [CNTW-1:0]   best_cnt_r;

  logic [IW-1:0]     req_idx;
  logic              in_range;
  logic              match;
  logic [CNTW-1:0]   cnt_fin;
  logic              take_best;

  assign req_idx  = IW'(req_r.site_index);
  assign in_range = (32'(req_r.site_index) < SLOTS);
  assign wr_addr  = req_idx;
  assign match    = pend_r && valid_r[pj_r] && (rd_data_r == v_r);
  assign cnt_fin  = cnt_r + CNTW'(match);
  assign take_best = (cnt_fin > best_cnt_r) ||
                     ((cnt_fin == best_cnt_r) && (v_r < best_r));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= req_r.size_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    rd_addr   = i_r;
    mem_we    = 1'b0;
    case (state_r)
      S_IDLE: begin
        rd_addr = IW'(in_data.site_index);
        if (start) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (req_r.opcode == OP_ADD) begin
          if (in_range && (!valid_r[req_idx] || rd_data_r != req_r.size_value)) begin
            mem_we    = 1'b1;
            state_nxt = S_OUTER;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = (in_range && valid_r[req_idx]) ? S_OUTER : S_DONE;
        end
      end
      S_OUTER: begin
        rd_addr = i_r;
        if (valid_r[i_r]) begin
          state_nxt = S_OUTER_CHK;
        end else if (i_r == LAST) begin
          state_nxt = S_FINAL;
        end
      end
      S_OUTER_CHK: begin
        if (rd_data_r != '0) begin
          state_nxt = S_INNER;
        end else begin
          state_nxt = (i_r == LAST) ? S_FINAL : S_OUTER;
        end
      end
      S_INNER: begin
        rd_addr = j_r;
        if (j_r == LAST) begin
          state_nxt = S_INNER_END;
        end
      end
      S_INNER_END: begin
        state_nxt = (i_r == LAST) ? S_FINAL : S_OUTER;
      end
      S_FINAL: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      count_r   <= '0;
      est_r     <= '0;
      changed_r <= 1'b0;
      full_r    <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r <= in_data;
          end
        end
        S_CHECK: begin
          changed_r  <= 1'b0;
          full_r     <= (req_r.opcode == OP_ADD) && !in_range;
          i_r        <= '0;
          best_r     <= '0;
          best_cnt_r <= '0;
          largest_r  <= '0;
          if (req_r.opcode == OP_ADD) begin
            if (in_range && (!valid_r[req_idx] || rd_data_r != req_r.size_value)) begin
              changed_r        <= 1'b1;
              valid_r[req_idx] <= 1'b1;
              if (!valid_r[req_idx]) begin
                count_r <= count_r + 1'b1;
              end
            end
          end else if (in_range && valid_r[req_idx]) begin
            changed_r        <= 1'b1;
            valid_r[req_idx] <= 1'b0;
            count_r          <= count_r - 1'b1;
          end
        end
        S_OUTER: begin
          if (!valid_r[i_r] && i_r != LAST) begin
            i_r <= i_r + 1'b1;
          end
        end
        S_OUTER_CHK: begin
          pend_r <= 1'b0;
          if (rd_data_r != '0) begin
            v_r   <= rd_data_r;
            cnt_r <= '0;
            j_r   <= '0;
          end else if (i_r != LAST) begin
            i_r <= i_r + 1'b1;
          end
        end
        S_INNER: begin
          // read of slot j is in flight while slot pj's data is compared
          cnt_r  <= cnt_fin;
          pend_r <= 1'b1;
          pj_r   <= j_r;
          if (j_r != LAST) begin
            j_r <= j_r + 1'b1;
          end
        end
        S_INNER_END: begin
          pend_r <= 1'b0;
          if (take_best) begin
            best_r     <= v_r;
            best_cnt_r <= cnt_fin;
          end
          if (v_r > largest_r) begin
            largest_r <= v_r;
          end
          if (i_r != LAST) begin
            i_r <= i_r + 1'b1;
          end
        end
        S_FINAL: begin
          // all distinct sizes: fall back to the largest
          est_r <= (best_cnt_r == CNTW'(1)) ? largest_r : best_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  always_comb begin
    out_data.changed        = changed_r;
    out_data.table_full     = full_r;
    out_data.estimated_size = est_r;
    out_data.site_count     = COUNT_W'(count_r);
  end

endmodule
